FILE: rtl/core/svps_pkg.sv
`timescale 1ns / 1ps
package svps_pkg;

  // Number formats.
  localparam int FRAC_BITS = 32;
  localparam int NORM_FRAC = 28;
  localparam int STEP_BITS = 16;
  localparam int DW        = 64;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [DW-1:0] LIMIT    = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [DW-1:0] LIM48    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [DW-1:0] MIN48    = 64'shFFFF_8000_0000_0000;
  localparam logic signed [DW-1:0] ONE      = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [DW-1:0] NORM_ONE = 64'sd1 <<< NORM_FRAC;
  localparam logic [STEP_BITS-1:0] STEP_MAX = '1;

  // Square root unit sizing: radicand is the value shifted up by FRAC_BITS.
  localparam int RAD_W    = DW + FRAC_BITS;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 4;
  localparam int SQ_CNT_W = $clog2(ROOT_W);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCHEME = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KAPPA  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THETA  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RHO    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MU     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DT     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SDT    = 3'd7;

  // Schemes.
  localparam logic [1:0] SCH_EULER = 2'd0;
  localparam logic [1:0] SCH_MIL   = 2'd1;
  localparam logic [1:0] SCH_TRUNC = 2'd2;
  localparam logic [1:0] SCH_REFL  = 2'd3;

  // Micro-op kinds.
  localparam logic [3:0] OP_MUL    = 4'd0;
  localparam logic [3:0] OP_SQRT   = 4'd1;
  localparam logic [3:0] OP_ADD    = 4'd2;
  localparam logic [3:0] OP_CFIX   = 4'd3;
  localparam logic [3:0] OP_M1     = 4'd4;
  localparam logic [3:0] OP_MSKIP  = 4'd5;
  localparam logic [3:0] OP_VFIX   = 4'd6;
  localparam logic [3:0] OP_COMMIT = 4'd7;
  localparam logic [3:0] OP_END    = 4'd8;

  // Operand sources.
  localparam logic [4:0] SRC_RHO   = 5'd0;
  localparam logic [4:0] SRC_Z1    = 5'd1;
  localparam logic [4:0] SRC_Z2    = 5'd2;
  localparam logic [4:0] SRC_KAPPA = 5'd3;
  localparam logic [4:0] SRC_THMV  = 5'd4;
  localparam logic [4:0] SRC_DT    = 5'd5;
  localparam logic [4:0] SRC_SDT   = 5'd6;
  localparam logic [4:0] SRC_SIGMA = 5'd7;
  localparam logic [4:0] SRC_MU    = 5'd8;
  localparam logic [4:0] SRC_S     = 5'd9;
  localparam logic [4:0] SRC_V     = 5'd10;
  localparam logic [4:0] SRC_T0    = 5'd11;
  localparam logic [4:0] SRC_T1    = 5'd12;
  localparam logic [4:0] SRC_W2    = 5'd13;
  localparam logic [4:0] SRC_SV    = 5'd14;
  localparam logic [4:0] SRC_VN    = 5'd15;
  localparam logic [4:0] SRC_SN    = 5'd16;

  // Destinations.
  localparam logic [2:0] DST_T0   = 3'd0;
  localparam logic [2:0] DST_T1   = 3'd1;
  localparam logic [2:0] DST_W2   = 3'd2;
  localparam logic [2:0] DST_SV   = 3'd3;
  localparam logic [2:0] DST_VN   = 3'd4;
  localparam logic [2:0] DST_SN   = 3'd5;
  localparam logic [2:0] DST_VOL  = 3'd6;
  localparam logic [2:0] DST_NONE = 3'd7;

  // Product shifts.
  localparam logic [1:0] SH_F = 2'd0;
  localparam logic [1:0] SH_N = 2'd1;
  localparam logic [1:0] SH_M = 2'd2;

  // Program entry points.
  localparam logic [4:0] PC_STEP    = 5'd0;
  localparam logic [4:0] PC_MIL_END = 5'd21;
  localparam logic [4:0] PC_VOL     = 5'd30;

  typedef struct packed {
    logic [3:0] kind;
    logic [4:0] src_a;
    logic [4:0] src_b;
    logic [1:0] sh;
    logic [2:0] dst;
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic accept;
    logic exec;
    logic mul_go;
    logic sqrt_go;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic sqrt_done;
    logic milstein;
  } stat_t;

  function automatic uop_t mk(input logic [3:0] kind, input logic [4:0] a,
                              input logic [4:0] b, input logic [1:0] sh,
                              input logic [2:0] dst);
    uop_t u;
    u.kind  = kind;
    u.src_a = a;
    u.src_b = b;
    u.sh    = sh;
    u.dst   = dst;
    return u;
  endfunction

  // Step program: correlated noise, variance update, price update, commit, root.
  function automatic uop_t uop_at(input logic [4:0] pc);
    uop_t u;
    case (pc)
      5'd0:  u = mk(OP_MUL, SRC_RHO, SRC_RHO, SH_F, DST_T0);
      5'd1:  u = mk(OP_CFIX, SRC_T0, SRC_T0, SH_F, DST_T0);
      5'd2:  u = mk(OP_SQRT, SRC_T0, SRC_T0, SH_F, DST_T0);
      5'd3:  u = mk(OP_MUL, SRC_T0, SRC_Z2, SH_F, DST_T1);
      5'd4:  u = mk(OP_MUL, SRC_RHO, SRC_Z1, SH_F, DST_T0);
      5'd5:  u = mk(OP_ADD, SRC_T0, SRC_T1, SH_F, DST_W2);
      5'd6:  u = mk(OP_SQRT, SRC_V, SRC_V, SH_F, DST_SV);
      5'd7:  u = mk(OP_MUL, SRC_KAPPA, SRC_THMV, SH_F, DST_T0);
      5'd8:  u = mk(OP_MUL, SRC_T0, SRC_DT, SH_F, DST_T0);
      5'd9:  u = mk(OP_ADD, SRC_V, SRC_T0, SH_F, DST_VN);
      5'd10: u = mk(OP_MUL, SRC_SIGMA, SRC_SV, SH_F, DST_T0);
      5'd11: u = mk(OP_MUL, SRC_T0, SRC_SDT, SH_F, DST_T0);
      5'd12: u = mk(OP_MUL, SRC_T0, SRC_W2, SH_N, DST_T0);
      5'd13: u = mk(OP_ADD, SRC_VN, SRC_T0, SH_F, DST_VN);
      5'd14: u = mk(OP_MSKIP, SRC_T0, SRC_T0, SH_F, DST_NONE);
      5'd15: u = mk(OP_MUL, SRC_W2, SRC_W2, SH_N, DST_T0);
      5'd16: u = mk(OP_M1, SRC_T0, SRC_T0, SH_F, DST_T0);
      5'd17: u = mk(OP_MUL, SRC_SIGMA, SRC_SIGMA, SH_F, DST_T1);
      5'd18: u = mk(OP_MUL, SRC_T1, SRC_DT, SH_F, DST_T1);
      5'd19: u = mk(OP_MUL, SRC_T1, SRC_T0, SH_M, DST_T0);
      5'd20: u = mk(OP_ADD, SRC_VN, SRC_T0, SH_F, DST_VN);
      5'd21: u = mk(OP_VFIX, SRC_VN, SRC_VN, SH_F, DST_VN);
      5'd22: u = mk(OP_MUL, SRC_MU, SRC_S, SH_F, DST_T0);
      5'd23: u = mk(OP_MUL, SRC_T0, SRC_DT, SH_F, DST_T0);
      5'd24: u = mk(OP_ADD, SRC_S, SRC_T0, SH_F, DST_SN);
      5'd25: u = mk(OP_MUL, SRC_SV, SRC_S, SH_F, DST_T0);
      5'd26: u = mk(OP_MUL, SRC_T0, SRC_SDT, SH_F, DST_T0);
      5'd27: u = mk(OP_MUL, SRC_T0, SRC_Z1, SH_N, DST_T0);
      5'd28: u = mk(OP_ADD, SRC_SN, SRC_T0, SH_F, DST_SN);
      5'd29: u = mk(OP_COMMIT, SRC_SN, SRC_VN, SH_F, DST_NONE);
      5'd30: u = mk(OP_SQRT, SRC_V, SRC_V, SH_F, DST_VOL);
      default: u = mk(OP_END, SRC_V, SRC_V, SH_F, DST_NONE);
    endcase
    return u;
  endfunction

endpackage

FILE: rtl/core/svps_mul.sv
`timescale 1ns / 1ps
module svps_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  logic [1:0]        sh,
  output logic              done,
  output logic signed [63:0] res,
  output logic              sat
);
  import svps_pkg::*;

  logic [63:0]  ua_r, ub_r;
  logic         neg_r;
  logic [1:0]   sh_r;
  logic [127:0] acc_r;
  logic [1:0]   cnt_r;
  logic         run_r, fin_r, done_r, sat_r;
  logic signed [63:0] res_r;

  logic [31:0]  a_part, b_part;
  logic [63:0]  pp;
  logic [1:0]   pos;
  logic [127:0] pp_sh;
  logic [127:0] q;
  logic         ovf;
  logic [63:0]  mag;

  // One 32x32 partial product per cycle, placed by its digit position.
  always_comb begin
    a_part = cnt_r[1] ? ua_r[63:32] : ua_r[31:0];
    b_part = cnt_r[0] ? ub_r[63:32] : ub_r[31:0];
    pp     = a_part * b_part;
    pos    = {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
    case (pos)
      2'd0:    pp_sh = {64'd0, pp};
      2'd1:    pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
  end

  // Truncating shift, saturation and sign of the finished product.
  always_comb begin
    case (sh_r)
      SH_N:    q = acc_r >> NORM_FRAC;
      SH_M:    q = acc_r >> (NORM_FRAC + 2);
      default: q = acc_r >> FRAC_BITS;
    endcase
    ovf = |q[127:62];
    mag = ovf ? LIMIT : q[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= fin_r;
      fin_r  <= run_r && (cnt_r == 2'd3);
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= 2'd0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      ua_r  <= a[63] ? 64'(-a) : 64'(a);
      ub_r  <= b[63] ? 64'(-b) : 64'(b);
      neg_r <= a[63] ^ b[63];
      sh_r  <= sh;
      acc_r <= '0;
    end else if (run_r) begin
      acc_r <= acc_r + pp_sh;
    end
    if (fin_r) begin
      res_r <= neg_r ? -$signed(mag) : $signed(mag);
      sat_r <= ovf;
    end
  end

  assign done = done_r;
  assign res  = res_r;
  assign sat  = sat_r;

endmodule

FILE: rtl/core/svps_sqrt.sv
`timescale 1ns / 1ps
module svps_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic signed [63:0]         x,
  output logic                       done,
  output logic [svps_pkg::ROOT_W-1:0] root
);
  import svps_pkg::*;

  logic [RAD_W-1:0]    rad_r;
  logic [REM_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [SQ_CNT_W-1:0] cnt_r;
  logic                run_r, done_r;

  logic [REM_W-1:0] rem_sh, trial;
  logic             ge;

  // One result bit per cycle by restoring digit recurrence.
  always_comb begin
    rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_r, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == SQ_CNT_W'(ROOT_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rad_r  <= (x > 64'sd0) ? {x, {FRAC_BITS{1'b0}}} : '0;
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= ge ? rem_sh - trial : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: rtl/core/svps_datapath.sv
`timescale 1ns / 1ps
module svps_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  svps_pkg::cmd_t                    cmd,
  output svps_pkg::stat_t                   stat,
  input  logic                              cfg_we,
  input  logic [svps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [svps_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_req_type,
  input  logic [46:0]                       in_start_price,
  input  logic [46:0]                       in_start_variance,
  input  logic signed [31:0]                in_normal_first,
  input  logic signed [31:0]                in_normal_second,
  output logic signed [47:0]                out_price_out,
  output logic signed [47:0]                out_variance_out,
  output logic [46:0]                       out_volatility_out,
  output logic [15:0]                       out_step_index,
  output logic                              out_saturated
);
  import svps_pkg::*;

  // Configuration.
  logic [1:0]         scheme_r;
  logic [46:0]        kappa_r, theta_r, sigma_r, dt_r, sdt_r;
  logic signed [33:0] rho_r;
  logic signed [47:0] mu_r;

  // Path state and working registers.
  logic signed [47:0]    price_r, var_r;
  logic [STEP_BITS-1:0]  steps_r;
  logic                  sat_r;
  logic signed [31:0]    z1_r, z2_r;
  logic signed [63:0]    t0_r, t1_r, w2_r, sv_r, vn_r, sn_r;
  logic [ROOT_W-1:0]     vol_r;

  logic signed [47:0] po_r, vo_r;
  logic [46:0]        volo_r;
  logic [15:0]        stepo_r;
  logic               sato_r;

  logic signed [63:0] op_a, op_b, v64, vpos, vx;
  logic               mul_done, mul_sat, sq_done;
  logic signed [63:0] mul_res;
  logic [ROOT_W-1:0]  sq_root;

  logic signed [64:0] sum65;
  logic signed [63:0] add_res, cfix, vfix;
  logic               add_sat;
  logic               wr_en, sat_set;
  logic signed [63:0] wr_val;
  logic signed [47:0] price_c, var_c;
  logic               commit_sat;

  function automatic logic signed [63:0] src_val(input logic [4:0] s,
      input logic signed [33:0] rho, input logic signed [31:0] z1,
      input logic signed [31:0] z2, input logic [46:0] kappa,
      input logic signed [63:0] thmv, input logic [46:0] dt, input logic [46:0] sdt,
      input logic [46:0] sigma, input logic signed [47:0] mu,
      input logic signed [47:0] sp, input logic signed [63:0] vv,
      input logic signed [63:0] t0, input logic signed [63:0] t1,
      input logic signed [63:0] w2, input logic signed [63:0] sv,
      input logic signed [63:0] vn, input logic signed [63:0] sn);
    logic signed [63:0] r;
    case (s)
      SRC_RHO:   r = 64'(rho);
      SRC_Z1:    r = 64'(z1);
      SRC_Z2:    r = 64'(z2);
      SRC_KAPPA: r = $signed({17'd0, kappa});
      SRC_THMV:  r = thmv;
      SRC_DT:    r = $signed({17'd0, dt});
      SRC_SDT:   r = $signed({17'd0, sdt});
      SRC_SIGMA: r = $signed({17'd0, sigma});
      SRC_MU:    r = 64'(mu);
      SRC_S:     r = 64'(sp);
      SRC_V:     r = vv;
      SRC_T0:    r = t0;
      SRC_T1:    r = t1;
      SRC_W2:    r = w2;
      SRC_SV:    r = sv;
      SRC_VN:    r = vn;
      SRC_SN:    r = sn;
      default:   r = '0;
    endcase
    return r;
  endfunction

  // Operand selection.
  always_comb begin
    v64  = 64'(var_r);
    vpos = (v64 > 64'sd0) ? v64 : 64'sd0;
    vx   = (scheme_r == SCH_REFL) ? v64 : vpos;
    op_a = src_val(cmd.uop.src_a, rho_r, z1_r, z2_r, kappa_r,
                   $signed({17'd0, theta_r}) - vx, dt_r, sdt_r, sigma_r, mu_r,
                   price_r, v64, t0_r, t1_r, w2_r, sv_r, vn_r, sn_r);
    op_b = src_val(cmd.uop.src_b, rho_r, z1_r, z2_r, kappa_r,
                   $signed({17'd0, theta_r}) - vx, dt_r, sdt_r, sigma_r, mu_r,
                   price_r, v64, t0_r, t1_r, w2_r, sv_r, vn_r, sn_r);
  end

  svps_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.mul_go),
    .a    (op_a),
    .b    (op_b),
    .sh   (cmd.uop.sh),
    .done (mul_done),
    .res  (mul_res),
    .sat  (mul_sat)
  );

  svps_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.sqrt_go),
    .x    (op_a),
    .done (sq_done),
    .root (sq_root)
  );

  // Saturating add and the CFIX and VFIX fixups.
  always_comb begin
    sum65   = {op_a[63], op_a} + {op_b[63], op_b};
    add_sat = 1'b0;
    add_res = sum65[63:0];
    if (sum65 > 65'(LIMIT)) begin
      add_res = LIMIT;
      add_sat = 1'b1;
    end else if (sum65 < -65'(LIMIT)) begin
      add_res = -LIMIT;
      add_sat = 1'b1;
    end
    cfix = ONE - t0_r;
    if (cfix < 64'sd0) begin
      cfix = '0;
    end
    vfix = vn_r;
    if (vn_r < 64'sd0 && scheme_r == SCH_TRUNC) begin
      vfix = '0;
    end else if (vn_r < 64'sd0 && scheme_r == SCH_REFL) begin
      vfix = -vn_r;
    end
  end

  // Register write-back selection.
  always_comb begin
    wr_en   = 1'b0;
    wr_val  = add_res;
    sat_set = 1'b0;
    if (mul_done) begin
      wr_en   = 1'b1;
      wr_val  = mul_res;
      sat_set = mul_sat;
    end else if (sq_done) begin
      wr_en  = 1'b1;
      wr_val = $signed({{(DW-ROOT_W){1'b0}}, sq_root});
    end else if (cmd.exec) begin
      case (cmd.uop.kind)
        OP_ADD: begin
          wr_en   = 1'b1;
          wr_val  = add_res;
          sat_set = add_sat;
        end
        OP_CFIX: begin
          wr_en  = 1'b1;
          wr_val = cfix;
        end
        OP_M1: begin
          wr_en  = 1'b1;
          wr_val = t0_r - NORM_ONE;
        end
        OP_VFIX: begin
          wr_en  = 1'b1;
          wr_val = vfix;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  // Final clamp of price and variance into the 48-bit state.
  always_comb begin
    commit_sat = 1'b0;
    price_c    = sn_r[47:0];
    if (sn_r > LIM48) begin
      price_c    = LIM48[47:0];
      commit_sat = 1'b1;
    end else if (sn_r < -LIM48) begin
      price_c    = 48'(-LIM48);
      commit_sat = 1'b1;
    end
    var_c = vn_r[47:0];
    if (vn_r > LIM48) begin
      var_c      = LIM48[47:0];
      commit_sat = 1'b1;
    end else if (vn_r < MIN48) begin
      var_c      = MIN48[47:0];
      commit_sat = 1'b1;
    end
    if (steps_r == STEP_MAX) begin
      commit_sat = 1'b1;
    end
  end

  // Configuration and path state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scheme_r <= SCH_EULER;
      kappa_r  <= 47'd8589934592;
      theta_r  <= 47'd171798692;
      sigma_r  <= 47'd1288490189;
      rho_r    <= -34'sd3006477107;
      mu_r     <= '0;
      dt_r     <= 47'd17043521;
      sdt_r    <= 47'd270557509;
      price_r  <= '0;
      var_r    <= '0;
      steps_r  <= '0;
      sat_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SCHEME: scheme_r <= cfg_wdata[1:0];
          REG_KAPPA:  kappa_r  <= cfg_wdata[46:0];
          REG_THETA:  theta_r  <= cfg_wdata[46:0];
          REG_SIGMA:  sigma_r  <= cfg_wdata[46:0];
          REG_RHO:    rho_r    <= cfg_wdata[33:0];
          REG_MU:     mu_r     <= cfg_wdata[47:0];
          REG_DT:     dt_r     <= cfg_wdata[46:0];
          REG_SDT:    sdt_r    <= cfg_wdata[46:0];
          default:    scheme_r <= scheme_r;
        endcase
      end
      if (cmd.accept) begin
        sat_r <= 1'b0;
        if (!in_req_type) begin
          price_r <= $signed({1'b0, in_start_price});
          var_r   <= $signed({1'b0, in_start_variance});
          steps_r <= '0;
        end
      end else if (cmd.exec && cmd.uop.kind == OP_COMMIT) begin
        price_r <= price_c;
        var_r   <= var_c;
        if (steps_r != STEP_MAX) begin
          steps_r <= steps_r + 1'b1;
        end
        sat_r <= sat_r | commit_sat;
      end else if (sat_set) begin
        sat_r <= 1'b1;
      end
    end
  end

  // Working registers and the output beat.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      z1_r <= in_normal_first;
      z2_r <= in_normal_second;
    end
    if (wr_en) begin
      case (cmd.uop.dst)
        DST_T0:  t0_r  <= wr_val;
        DST_T1:  t1_r  <= wr_val;
        DST_W2:  w2_r  <= wr_val;
        DST_SV:  sv_r  <= wr_val;
        DST_VN:  vn_r  <= wr_val;
        DST_SN:  sn_r  <= wr_val;
        DST_VOL: vol_r <= wr_val[ROOT_W-1:0];
        default: t0_r  <= t0_r;
      endcase
    end
    if (cmd.load_out) begin
      po_r    <= price_r;
      vo_r    <= var_r;
      volo_r  <= vol_r[46:0];
      stepo_r <= 16'(steps_r);
      sato_r  <= sat_r;
    end
  end

  assign stat.mul_done  = mul_done;
  assign stat.sqrt_done = sq_done;
  assign stat.milstein  = (scheme_r == SCH_MIL);

  assign out_price_out      = po_r;
  assign out_variance_out   = vo_r;
  assign out_volatility_out = volo_r;
  assign out_step_index     = stepo_r;
  assign out_saturated      = sato_r;

endmodule

FILE: rtl/core/svps_ctrl.sv
`timescale 1ns / 1ps
module svps_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_req_type,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  svps_pkg::stat_t stat,
  output svps_pkg::cmd_t  cmd
);
  import svps_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [4:0] pc_r, pc_nxt;
  logic       out_valid_r, out_valid_nxt;
  uop_t       op;

  // Sequencer over the micro-program.
  always_comb begin
    op            = uop_at(pc_r);
    cmd           = '0;
    cmd.uop       = op;
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          pc_nxt     = in_req_type ? PC_STEP : PC_VOL;
          state_nxt  = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        case (op.kind)
          OP_MUL: begin
            cmd.mul_go = 1'b1;
            state_nxt  = ST_WAIT;
          end
          OP_SQRT: begin
            cmd.sqrt_go = 1'b1;
            state_nxt   = ST_WAIT;
          end
          OP_MSKIP: begin
            pc_nxt = stat.milstein ? pc_r + 5'd1 : PC_MIL_END;
          end
          OP_END: begin
            if (!out_valid_r || !out_stall) begin
              cmd.load_out = 1'b1;
              state_nxt    = ST_IDLE;
            end
          end
          default: begin
            cmd.exec = 1'b1;
            pc_nxt   = pc_r + 5'd1;
          end
        endcase
      end
      ST_WAIT: begin
        if (stat.mul_done || stat.sqrt_done) begin
          pc_nxt    = pc_r + 5'd1;
          state_nxt = ST_ISSUE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = cmd.load_out | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/core/stochastic_volatility_path_step.sv
`timescale 1ns / 1ps
// Stochastic-volatility path stepper.
// Input channel (in_valid / in_stall): a beat with in_req_type 0 starts a new
// path from in_start_price and in_start_variance; a beat with in_req_type 1
// advances the path one time step using the two normal samples.
// Output channel (out_valid / out_stall): every input beat yields exactly one
// output beat with price, variance, volatility, step index and saturation flag.
// Configuration: cfg_we writes cfg_wdata into register cfg_index; write only
// while no request is in flight.
// A start runs one square root for the volatility. A step runs three square
// roots, 13 or 17 products (17 with the Milstein scheme) on one shared 32x32
// multiplier, and 9 or 11 other micro-ops before the closing one (11 with
// Milstein). One request is in work at a time.
// in_stall is high from acceptance until the result is placed
// in the output register; a held result does not block the next acceptance,
// only the delivery of that next result.
// Reset (synchronous, rst_n low) restores the configuration defaults, clears
// the path state to zero and empties the output register.
module stochastic_volatility_path_step (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [svps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [svps_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_req_type,
  input  logic [46:0]                    in_start_price,
  input  logic [46:0]                    in_start_variance,
  input  logic signed [31:0]             in_normal_first,
  input  logic signed [31:0]             in_normal_second,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [47:0]             out_price_out,
  output logic signed [47:0]             out_variance_out,
  output logic [46:0]                    out_volatility_out,
  output logic [15:0]                    out_step_index,
  output logic                           out_saturated
);
  import svps_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  svps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_req_type(in_req_type),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  svps_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_req_type       (in_req_type),
    .in_start_price    (in_start_price),
    .in_start_variance (in_start_variance),
    .in_normal_first   (in_normal_first),
    .in_normal_second  (in_normal_second),
    .out_price_out     (out_price_out),
    .out_variance_out  (out_variance_out),
    .out_volatility_out(out_volatility_out),
    .out_step_index    (out_step_index),
    .out_saturated     (out_saturated)
  );

  // The block is busy in the cycle after it takes a beat.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block not busy after accepting a beat");

  // A new result is placed only as the sequencer returns to idle.
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result delivered while sequencer still busy");

  // Negative variance has zero volatility.
  a_neg_var_vol: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_variance_out[47]) |-> (out_volatility_out == 47'd0))
    else $error("nonzero volatility for negative variance");

endmodule
